[rtl/nearest_point_search_2d_defines.svh]
// assertion macros shared by the checker of nearest_point_search_2d
// each macro samples on clk and is disabled while arst_n is low
`ifndef NEAREST_POINT_SEARCH_2D_DEFINES_SVH
`define NEAREST_POINT_SEARCH_2D_DEFINES_SVH

// condition implies consequence in the same cycle
`define NPS_ASSERT_SAME(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("nps check failed");

// condition implies consequence in the next cycle
`define NPS_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("nps check failed");

`endif

[rtl/nps_pkg.sv]
// shared types, sizes and codes for the nearest point search block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

	localparam int MAX_POINTS = 512;
	localparam int COORD_BITS = 16;
	localparam int ID_BITS    = 16;
	localparam int IDX_BITS   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
	localparam int MAG_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * MAG_BITS;
	localparam int DIST_BITS  = SQ_BITS + 1;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [ID_BITS-1:0]           id_t;
	typedef logic [DIST_BITS-1:0]         dist_t;

	typedef struct packed {
		coord_t phi;
		coord_t eta;
		id_t    id;
	} point_t;

endpackage

`default_nettype wire

[rtl/nps_req_if.sv]
// request channel: opcode, point to append and point to query
// depends on nps_pkg
`timescale 1ns / 1ps
`default_nettype none

interface nps_req_if
	import nps_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	coord_t     entry_phi;
	coord_t     entry_eta;
	id_t        entry_id;
	coord_t     query_phi;
	coord_t     query_eta;

	modport source (output valid, opcode, entry_phi, entry_eta, entry_id, query_phi,
		query_eta, input ready);
	modport sink (input valid, opcode, entry_phi, entry_eta, entry_id, query_phi,
		query_eta, output ready);
endinterface

`default_nettype wire

[rtl/nps_rsp_if.sv]
// response channel: status and identifier of the nearest point
// depends on nps_pkg
`timescale 1ns / 1ps
`default_nettype none

interface nps_rsp_if
	import nps_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	id_t        nearest_id;

	modport source (output valid, status, nearest_id, input ready);
	modport sink (input valid, status, nearest_id, output ready);
endinterface

`default_nettype wire

[rtl/nps_dist.sv]
// two-stage squared distance unit shared by every entry of a query scan
// depends on nps_pkg
`timescale 1ns / 1ps
`default_nettype none

module nps_dist
	import nps_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   valid_s1,
	input  wire point_t entry_s1,
	input  wire coord_t query_phi,
	input  wire coord_t query_eta,
	output logic        valid_s2,
	output logic        valid_s3,
	output dist_t       dist_s3,
	output id_t         id_s3
);

	logic signed [MAG_BITS-1:0] dphi;
	logic signed [MAG_BITS-1:0] deta;
	logic [MAG_BITS-1:0]        mag_phi_s2;
	logic [MAG_BITS-1:0]        mag_eta_s2;
	id_t                        id_s2;
	logic [SQ_BITS-1:0]         sq_phi_s3;
	logic [SQ_BITS-1:0]         sq_eta_s3;

	// differences one bit wider so nothing wraps
	assign dphi = {entry_s1.phi[COORD_BITS-1], entry_s1.phi} - {query_phi[COORD_BITS-1], query_phi};
	assign deta = {entry_s1.eta[COORD_BITS-1], entry_s1.eta} - {query_eta[COORD_BITS-1], query_eta};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_phi_s2 <= dphi[MAG_BITS-1] ? MAG_BITS'(-dphi) : MAG_BITS'(dphi);
		mag_eta_s2 <= deta[MAG_BITS-1] ? MAG_BITS'(-deta) : MAG_BITS'(deta);
		id_s2      <= entry_s1.id;
		sq_phi_s3  <= SQ_BITS'(mag_phi_s2) * SQ_BITS'(mag_phi_s2);
		sq_eta_s3  <= SQ_BITS'(mag_eta_s2) * SQ_BITS'(mag_eta_s2);
		id_s3      <= id_s2;
	end

	assign dist_s3 = DIST_BITS'(sq_phi_s3) + DIST_BITS'(sq_eta_s3);

endmodule

`default_nettype wire

[rtl/nearest_point_search_2d.sv]
// clear, append or append-order nearest search over a table of 2-D points
// clear, append and unused opcodes go from acceptance straight to the output stage
// a query first scans the n stored points in append order; on an empty table it goes straight to the output stage
// a new request is taken only while the sequencer is idle; the scan uses the one table read port
// reset: arst_n clears the point count, sequencer and output valid; table contents stay
// depends on nps_pkg, nps_req_if, nps_rsp_if, nps_dist
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_search_2d
	import nps_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	nps_req_if.sink   req,
	nps_rsp_if.source rsp
);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_PUT   = 2'd3;

	logic [1:0]          state_q;
	logic [CNT_BITS-1:0] count_q;
	logic [IDX_BITS-1:0] scan_idx_q;
	logic                accept;
	logic                last_issue;
	logic                busy;

	// point table, one write or one read per cycle
	point_t              point_mem [MAX_POINTS];
	logic                wr_en;
	logic                rd_en;
	point_t              rd_data_s1;
	logic                valid_s1;

	// query operands and running best
	coord_t              qphi_q;
	coord_t              qeta_q;
	logic                first_q;
	dist_t               best_dist_q;
	id_t                 best_id_q;

	// distance unit outputs
	logic                valid_s2;
	logic                valid_s3;
	dist_t               dist_s3;
	id_t                 id_s3;

	// finished word waiting for the output register
	logic [1:0]          res_status_q;
	id_t                 res_id_q;

	// output register
	logic                ovalid_q;
	logic [1:0]          ostatus_q;
	id_t                 oid_q;
	logic                out_free;

	// a new request is taken whenever the sequencer is idle, even while
	// the previous word still sits in the output register
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign wr_en      = accept && (req.opcode == OP_APPEND) && (count_q != CNT_BITS'(MAX_POINTS));
	assign rd_en      = (state_q == S_SCAN);
	assign last_issue = (CNT_BITS'(scan_idx_q) + CNT_BITS'(1)) == count_q;
	// every stage of the distance pipe counts, or a one-entry scan ends early
	assign busy       = valid_s1 || valid_s2 || valid_s3 || (state_q == S_SCAN);
	assign out_free   = !ovalid_q || rsp.ready;

	// table storage, no reset: only entries below the count are read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			point_mem[count_q[IDX_BITS-1:0]] <= '{phi: req.entry_phi, eta: req.entry_eta,
				id: req.entry_id};
		end
		if (rd_en) begin
			rd_data_s1 <= point_mem[scan_idx_q];
		end
	end

	nps_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.entry_s1  (rd_data_s1),
		.query_phi (qphi_q),
		.query_eta (qeta_q),
		.valid_s2  (valid_s2),
		.valid_s3  (valid_s3),
		.dist_s3   (dist_s3),
		.id_s3     (id_s3)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			valid_s1   <= 1'b0;
			first_q    <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			valid_s1 <= rd_en;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_PUT;
							end
							OP_APPEND: begin
								if (count_q != CNT_BITS'(MAX_POINTS)) begin
									count_q <= count_q + CNT_BITS'(1);
								end
								state_q <= S_PUT;
							end
							OP_QUERY: begin
								scan_idx_q <= '0;
								first_q    <= 1'b1;
								state_q    <= (count_q == '0) ? S_PUT : S_SCAN;
							end
							default: begin
								state_q <= S_PUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (last_issue) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_BITS'(1);
					end
				end
				S_DRAIN: begin
					if (!busy) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// first entry seen always wins, later ones only when strictly nearer
			if (valid_s3) begin
				first_q <= 1'b0;
			end

			if ((state_q == S_PUT) && out_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			qphi_q <= req.query_phi;
			qeta_q <= req.query_eta;
			res_id_q <= '0;
			if ((req.opcode == OP_APPEND) && (count_q == CNT_BITS'(MAX_POINTS))) begin
				res_status_q <= ST_FULL;
			end else if ((req.opcode == OP_QUERY) && (count_q == '0)) begin
				res_status_q <= ST_EMPTY;
			end else begin
				res_status_q <= ST_OK;
			end
		end

		if (valid_s3 && (first_q || (dist_s3 < best_dist_q))) begin
			best_dist_q <= dist_s3;
			best_id_q   <= id_s3;
		end

		// scan finished: the best identifier becomes the word
		if ((state_q == S_DRAIN) && !busy) begin
			res_status_q <= ST_OK;
			res_id_q     <= best_id_q;
		end

		if ((state_q == S_PUT) && out_free) begin
			ostatus_q <= res_status_q;
			oid_q     <= res_id_q;
		end
	end

	assign rsp.valid      = ovalid_q;
	assign rsp.status     = ostatus_q;
	assign rsp.nearest_id = oid_q;

endmodule

`default_nettype wire

[rtl/nps_chk.sv]
// port-level checks for nearest_point_search_2d, attached by bind
// depends on nps_pkg and nearest_point_search_2d_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_point_search_2d_defines.svh"

module nps_chk
	import nps_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] rsp_status,
	input wire id_t        rsp_nearest_id
);

	// a stalled word stays put
	`NPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_nearest_id))

	// status never carries the unused code, the empty code being the highest
	`NPS_ASSERT_SAME(a_status_code, rsp_valid, rsp_status <= ST_EMPTY)

	// identifier is zero unless the word reports success
	`NPS_ASSERT_SAME(a_id_zero, rsp_valid && rsp_status != ST_OK, rsp_nearest_id == '0)

	// one request at a time: taking a word closes the request side in the next cycle
	`NPS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind nearest_point_search_2d nps_chk u_nps_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_nearest_id (rsp.nearest_id)
);

`default_nettype wire

[test/tb_nearest_point_search_2d.sv]
`timescale 1ns / 1ps
// self-checking bench for nearest_point_search_2d: directed words, then random episodes
// of clears, appends and queries, checked word by word against a shadow point table
// depends on nps_pkg, nps_req_if, nps_rsp_if and the block under test

module tb_nearest_point_search_2d;
	import nps_pkg::*;

	// the one opcode the package leaves unnamed; the block must treat it as a no-op
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int ITEM_TARGET     = 1170;
	localparam int FILL_AFTER      = 350;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = MAX_POINTS + 16;
	// worst case is far below this: ~1200 words, each at most a full-table search
	// plus the longest receiver stall and sender gap, taken several times over
	localparam longint CYCLE_LIMIT = 4_000_000;

	typedef struct {
		logic [1:0] status;
		id_t        nearest_id;
	} search_word_t;

	// shadow of the point table plus the queue of words still owed by the block
	class search_tracker;
		point_t       points [MAX_POINTS];
		int           stored;
		search_word_t pending [$];
		int           failures;
		int           clears, appends, drops, queries, empty_queries, unused_ops;

		// exact squared distance in squared coordinate steps, at most 2^33
		function longint unsigned distance_sq(point_t p, coord_t q_phi, coord_t q_eta);
			longint d_phi, d_eta;
			d_phi = longint'($signed(p.phi)) - longint'($signed(q_phi));
			d_eta = longint'($signed(p.eta)) - longint'($signed(q_eta));
			return unsigned'(d_phi * d_phi + d_eta * d_eta);
		endfunction

		// walk the table in append order, strictly smaller wins so ties go to the earliest
		function id_t nearest_to(coord_t q_phi, coord_t q_eta);
			longint unsigned best, d;
			id_t best_id;
			best    = distance_sq(points[0], q_phi, q_eta);
			best_id = points[0].id;
			for (int i = 1; i < stored; i++) begin
				d = distance_sq(points[i], q_phi, q_eta);
				if (d < best) begin
					best    = d;
					best_id = points[i].id;
				end
			end
			return best_id;
		endfunction

		function void note_request(logic [1:0] op, point_t entry, coord_t q_phi,
				coord_t q_eta);
			search_word_t w;
			w.status     = ST_OK;
			w.nearest_id = '0;
			case (op)
			OP_CLEAR: begin
				stored = 0;
				clears++;
			end
			OP_APPEND: begin
				if (stored >= MAX_POINTS) begin
					w.status = ST_FULL;
					drops++;
				end else begin
					points[stored] = entry;
					stored++;
					appends++;
				end
			end
			OP_QUERY: begin
				queries++;
				if (stored == 0) begin
					w.status = ST_EMPTY;
					empty_queries++;
				end else begin
					w.nearest_id = nearest_to(q_phi, q_eta);
				end
			end
			default: begin
				unused_ops++;
			end
			endcase
			pending = {pending, w};
		endfunction

		function void check_word(logic [1:0] status, id_t nearest_id);
			search_word_t w;
			if (pending.size() == 0) begin
				$error("word with nothing expected: status %0d, nearest_id %h",
					status, nearest_id);
				failures++;
			end else begin
				w = pending.pop_front();
				if (status !== w.status) begin
					$error("status mismatch: expected %0d, actual %0d", w.status, status);
					failures++;
				end
				if (nearest_id !== w.nearest_id) begin
					$error("nearest_id mismatch: expected %h, actual %h",
						w.nearest_id, nearest_id);
					failures++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	nps_req_if req_ch ();
	nps_rsp_if rsp_ch ();

	nearest_point_search_2d dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	search_tracker tracker = new();

	int     items_sent;
	int     burst_left;
	bit     filled;
	bit     hold_off_request;
	int     hold_count;
	int     stall_mode;
	int     stall_span;
	int     stall_phase;
	longint cycle_count;

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic point_t point_of(int phi, int eta, int id);
		point_t r;
		r.phi = coord_t'(phi);
		r.eta = coord_t'(eta);
		r.id  = id_t'(id);
		return r;
	endfunction

	function automatic coord_t any_coord();
		return coord_t'($urandom);
	endfunction

	// a third of the points sit in a tiny window around the origin so that
	// equal distances, and hence the earliest-entry rule, come up often
	function automatic point_t random_point();
		point_t r;
		if ($urandom_range(0, 2) == 0) begin
			r.phi = coord_t'(int'($urandom_range(0, 15)) - 8);
			r.eta = coord_t'(int'($urandom_range(0, 15)) - 8);
		end else begin
			r.phi = any_coord();
			r.eta = any_coord();
		end
		r.id = id_t'($urandom);
		return r;
	endfunction

	// small step around a coordinate, wrapping at the ends of the range
	function automatic coord_t nudge(coord_t c);
		return c + coord_t'(int'($urandom_range(0, 6)) - 3);
	endfunction

	// offer one request word and hold it until the block takes it; the sender
	// runs in bursts of random length separated by random gaps
	task automatic offer_request(logic [1:0] op, point_t entry, coord_t q_phi,
			coord_t q_eta);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= op;
		req_ch.entry_phi <= entry.phi;
		req_ch.entry_eta <= entry.eta;
		req_ch.entry_id  <= entry.id;
		req_ch.query_phi <= q_phi;
		req_ch.query_eta <= q_eta;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		tracker.note_request(op, entry, q_phi, q_eta);
		items_sent++;
		burst_left--;
	endtask

	task automatic clear_table();
		offer_request(OP_CLEAR, random_point(), any_coord(), any_coord());
	endtask

	task automatic append_point(point_t p);
		offer_request(OP_APPEND, p, any_coord(), any_coord());
	endtask

	task automatic query_at(coord_t q_phi, coord_t q_eta);
		offer_request(OP_QUERY, random_point(), q_phi, q_eta);
	endtask

	// sender goes quiet until every owed word has come back
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	// one short well-formed sequence: maybe a clear, a run of appends, then queries
	// near stored points, in the tie window or anywhere, with the odd unused opcode
	task automatic run_episode();
		int n_app, n_q, pick;
		point_t p;
		if (tracker.stored > 400 || $urandom_range(0, 3) != 0)
			clear_table();
		// occasionally query before anything is appended (empty table if just cleared)
		if ($urandom_range(0, 9) == 0)
			query_at(any_coord(), any_coord());
		n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
		repeat (n_app) begin
			if (tracker.stored != 0 && $urandom_range(0, 5) == 0) begin
				// copy of an earlier point under a fresh identifier, an exact tie
				p    = tracker.points[$urandom_range(0, tracker.stored - 1)];
				p.id = id_t'($urandom);
				append_point(p);
			end else begin
				append_point(random_point());
			end
		end
		n_q = $urandom_range(1, 6);
		repeat (n_q) begin
			pick = $urandom_range(0, 9);
			if (pick < 4 && tracker.stored != 0) begin
				p = tracker.points[$urandom_range(0, tracker.stored - 1)];
				query_at(nudge(p.phi), nudge(p.eta));
			end else if (pick < 6) begin
				query_at(coord_t'(int'($urandom_range(0, 15)) - 8),
					coord_t'(int'($urandom_range(0, 15)) - 8));
			end else if (pick == 9) begin
				offer_request(OP_UNUSED, random_point(), any_coord(), any_coord());
			end else begin
				query_at(any_coord(), any_coord());
			end
		end
	endtask

	// the one full-table pass: fill every slot, bounce two appends off the
	// top, then a few searches over the whole depth
	task automatic fill_table();
		point_t p;
		wait_for_results();
		clear_table();
		repeat (MAX_POINTS) append_point(random_point());
		repeat (2) append_point(random_point());
		p = tracker.points[$urandom_range(0, MAX_POINTS - 1)];
		query_at(p.phi, p.eta);
		p = tracker.points[MAX_POINTS - 1];
		query_at(nudge(p.phi), nudge(p.eta));
		query_at(any_coord(), any_coord());
	endtask

	// ------------------------------------------------------------------
	// receiver: own stall pattern, plus one long hold-off on request
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (hold_off_request) begin
			rsp_ch.ready <= 1'b0;
			hold_count++;
			if (hold_count >= HOLD_OFF_CYCLES) begin
				hold_off_request = 1'b0;
				hold_count       = 0;
			end
		end else begin
			if (stall_span == 0) begin
				stall_mode  = $urandom_range(0, 3);
				stall_span  = $urandom_range(4, 40);
				stall_phase = 0;
			end
			stall_span--;
			stall_phase++;
			case (stall_mode)
			0: rsp_ch.ready <= 1'b1;                            // free-running
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));         // coin toss
			2: rsp_ch.ready <= (stall_phase % 4) != 0;           // one stall in four
			default: rsp_ch.ready <= ($urandom_range(0, 7) == 0); // mostly stalled
			endcase
		end
	end

	// result monitor: every accepted word is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_word(rsp_ch.status, rsp_ch.nearest_id);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timed out after %0d cycles with %0d words owed",
				cycle_count, tracker.pending.size());
			$display("nearest_point_search_2d regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = OP_CLEAR;
		req_ch.entry_phi = '0;
		req_ch.entry_eta = '0;
		req_ch.entry_id  = '0;
		req_ch.query_phi = '0;
		req_ch.query_eta = '0;
		rsp_ch.ready     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		query_at(coord_t'(-32768), coord_t'(32767));           // empty table straight after reset
		append_point(point_of(-32768, -32768, 0));
		query_at(coord_t'(32767), coord_t'(32767));            // widest possible separation
		append_point(point_of(32767, 32767, 16'hFFFF));
		query_at(coord_t'(32767), coord_t'(32767));
		query_at(coord_t'(-32768), coord_t'(-32768));
		query_at(coord_t'(0), coord_t'(0));                    // just nearer the top corner
		append_point(point_of(16'h1234, -5, 16'hA5A5));
		append_point(point_of(16'h1234, -5, 16'h5A5A));        // same spot, later entry
		query_at(coord_t'(16'h1234), coord_t'(-5));            // earlier duplicate must win
		clear_table();
		append_point(point_of(10, 0, 16'h0011));
		append_point(point_of(-10, 0, 16'h0022));
		append_point(point_of(0, 10, 16'h0033));
		query_at(coord_t'(0), coord_t'(0));                    // three-way tie
		query_at(coord_t'(0), coord_t'(1));
		offer_request(OP_UNUSED, point_of(-1, -1, 16'hFFFF), coord_t'(-1), coord_t'(-1));
		query_at(coord_t'(0), coord_t'(1));                    // table untouched by the no-op
		clear_table();
		query_at(coord_t'(0), coord_t'(0));
		clear_table();                                         // clear of an empty table

		// long receiver hold-off while appends keep coming, so the block backs up
		clear_table();
		hold_off_request = 1'b1;
		repeat (16) append_point(random_point());
		query_at(any_coord(), any_coord());
		wait_for_results();

		// random part
		while (items_sent < ITEM_TARGET) begin
			if (!filled && items_sent >= FILL_AFTER) begin
				fill_table();
				filled = 1'b1;
			end else begin
				if ($urandom_range(0, 9) == 0)
					wait_for_results();
				run_episode();
			end
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.pending.size() != 0) begin
			$error("%0d expected words never arrived", tracker.pending.size());
			tracker.failures++;
		end

		$display("covered %0d words: %0d clears, %0d appends, %0d appends refused when full,",
			items_sent, tracker.clears, tracker.appends, tracker.drops);
		$display("  %0d searches (%0d on an empty table), %0d unused opcodes, %0d errors",
			tracker.queries, tracker.empty_queries, tracker.unused_ops, tracker.failures);
		if (tracker.failures == 0)
			$display("nearest_point_search_2d regression: pass");
		else
			$display("nearest_point_search_2d regression: fail");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_req_if.sv
rtl/nps_rsp_if.sv
rtl/nps_dist.sv
rtl/nearest_point_search_2d.sv
rtl/nps_chk.sv
test/tb_nearest_point_search_2d.sv
